/* hdl/dmc_pkg.sv */
// shared types and constants for the dual monod cell rate block
package dmc_pkg;

    localparam int WORD_W     = 32;
    localparam int MAG_W      = 48;
    localparam int QUO_W      = 17;
    localparam int REM_W      = WORD_W + 1;
    localparam int DIV_STAGES = QUO_W;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [MAG_W-1:0]  mag_t;
    typedef logic [QUO_W-1:0]  quo_t;
    typedef logic [REM_W-1:0]  rem_t;

    // magnitudes saturate here; any larger value already saturates a result
    localparam mag_t MAG_SAT = mag_t'(1) << (MAG_W - 1);

    // 0.65 in q16.16
    localparam word_t EXPORT_SHARE = 32'd42598;

    typedef enum logic [2:0] {
        REG_MAX_GROWTH   = 3'd0,
        REG_SUBST_AFF    = 3'd1,
        REG_METAB_AFF    = 3'd2,
        REG_INV_YIELD    = 3'd3,
        REG_LOSS_RATE    = 3'd4,
        REG_MATRIX_RATIO = 3'd5,
        REG_EXPORT_COST  = 3'd6,
        REG_GROWTH_SCALE = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        word_t dens;
        logic  grid;
        logic  last;
    } side_t;

endpackage

/* hdl/dmc_in_if.sv */
// input item channel: one grid cell
interface dmc_in_if;
    logic         valid;
    logic         ready;
    logic [31:0]  substrate_conc;
    logic [31:0]  metabolite_conc;
    logic [31:0]  biomass_density;
    logic         in_grid;
    logic         last_cell;

    modport source (output valid, output substrate_conc, output metabolite_conc,
                    output biomass_density, output in_grid, output last_cell,
                    input ready);
    modport sink (input valid, input substrate_conc, input metabolite_conc,
                  input biomass_density, input in_grid, input last_cell,
                  output ready);
endinterface

/* hdl/dmc_out_if.sv */
// result item channel: rates of one grid cell
interface dmc_out_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  substrate_delta;
    logic signed [31:0]  metabolite_delta;
    logic signed [31:0]  export_delta;
    logic signed [31:0]  net_growth;
    logic signed [31:0]  matrix_growth;
    logic                last_out;

    modport source (output valid, output substrate_delta, output metabolite_delta,
                    output export_delta, output net_growth, output matrix_growth,
                    output last_out, input ready);
    modport sink (input valid, input substrate_delta, input metabolite_delta,
                  input export_delta, input net_growth, input matrix_growth,
                  input last_out, output ready);
endinterface

/* hdl/dual_monod_cell_rates.sv */
// top level: dual-substrate monod rates and reaction deltas per grid cell
//
//  channel    dir  handshake          contents
//  cell_in    in   valid/ready        substrate, metabolite, biomass, in_grid, last
//  cell_out   out  valid/ready        three deltas, net growth, matrix growth, last
//  cfg        in   cfg_we (no ready)  register index cfg_addr, value cfg_data
//
// one item per cycle sustained while the skid stage is empty; the pipe is made of
// the two 17-stage dividers and five rounds of two-stage multipliers
// rst_n clears the valid bits and the skid stage and sets the configuration registers to their defaults
// a full skid stage freezes the whole pipe and drops cell_in.ready
module dual_monod_cell_rates (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  dmc_pkg::cfg_idx_t cfg_addr,
    input  dmc_pkg::word_t   cfg_data,
    dmc_in_if.sink           cell_in,
    dmc_out_if.source        cell_out
);
    import dmc_pkg::*;

    localparam int LAST_STAGE = 29;
    localparam int SIDE_LAST  = 28;

    // configuration registers
    word_t max_growth_reg;
    word_t subst_aff_reg;
    word_t metab_aff_reg;
    word_t inv_yield_reg;
    word_t loss_rate_reg;
    word_t matrix_ratio_reg;
    word_t export_cost_reg;
    word_t growth_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_growth_reg   <= 32'd0;
            subst_aff_reg    <= 32'd65536;
            metab_aff_reg    <= 32'd65536;
            inv_yield_reg    <= 32'd65536;
            loss_rate_reg    <= 32'd0;
            matrix_ratio_reg <= 32'd0;
            export_cost_reg  <= 32'hFFFF_EB64;
            growth_scale_reg <= 32'd68223;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MAX_GROWTH:   max_growth_reg   <= cfg_data;
                REG_SUBST_AFF:    subst_aff_reg    <= cfg_data;
                REG_METAB_AFF:    metab_aff_reg    <= cfg_data;
                REG_INV_YIELD:    inv_yield_reg    <= cfg_data;
                REG_LOSS_RATE:    loss_rate_reg    <= cfg_data;
                REG_MATRIX_RATIO: matrix_ratio_reg <= cfg_data;
                REG_EXPORT_COST:  export_cost_reg  <= cfg_data;
                REG_GROWTH_SCALE: growth_scale_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // sign and magnitude of the export cost factor
    logic  ecf_neg;
    word_t ecf_mag;
    assign ecf_neg = export_cost_reg[WORD_W-1];
    assign ecf_mag = ecf_neg ? (~export_cost_reg + 32'd1) : export_cost_reg;

    // pipe control: everything advances unless the skid stage is holding an item
    logic                  en;
    logic                  skid_valid_reg;
    logic [LAST_STAGE:0]   v_reg;

    assign en            = !skid_valid_reg;
    assign cell_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAST_STAGE-1:0], cell_in.valid};
        end
    end

    // stage 0 input register and side data shift line
    word_t s_reg;
    word_t m_reg;
    side_t side_reg [0:SIDE_LAST];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg       <= cell_in.substrate_conc;
            m_reg       <= cell_in.metabolite_conc;
            side_reg[0] <= '{dens: cell_in.biomass_density, grid: cell_in.in_grid,
                             last: cell_in.last_cell};
            for (int k = 1; k <= SIDE_LAST; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // monod quotients, ready at stage 17
    quo_t qs;
    quo_t qm;

    dmc_div u_div_s (.clk(clk), .en(en), .conc(s_reg), .aff(subst_aff_reg), .quo(qs));
    dmc_div u_div_m (.clk(clk), .en(en), .conc(m_reg), .aff(metab_aff_reg), .quo(qm));

    // rate = max_growth * qs * qm, stages 18 to 21
    mag_t  p_a;
    mag_t  p_rate;
    quo_t  qm_d_reg [0:1];

    dmc_mulq u_mul_a (.clk(clk), .en(en), .a({16'd0, max_growth_reg}),
                      .b({15'd0, qs}), .p(p_a));
    dmc_mulq u_mul_rate (.clk(clk), .en(en), .a(p_a),
                         .b({15'd0, qm_d_reg[1]}), .p(p_rate));

    // export term, scaled growth, export share and rate over yield, stages 22 and 23
    word_t rate;
    mag_t  p_extra;
    mag_t  p_scaled;
    mag_t  p_share;
    mag_t  p_riy;
    word_t rate_d_reg [0:1];

    assign rate = p_rate[WORD_W-1:0];

    dmc_mulq u_mul_extra (.clk(clk), .en(en), .a({16'd0, rate}), .b(ecf_mag), .p(p_extra));
    dmc_mulq u_mul_scaled (.clk(clk), .en(en), .a({16'd0, rate}), .b(growth_scale_reg),
                           .p(p_scaled));
    dmc_mulq u_mul_share (.clk(clk), .en(en), .a({16'd0, EXPORT_SHARE}), .b(inv_yield_reg),
                          .p(p_share));
    dmc_mulq u_mul_riy (.clk(clk), .en(en), .a({16'd0, rate}), .b(inv_yield_reg), .p(p_riy));

    // stage 24: rate plus export term as sign and magnitude
    mag_t  sum_mag_next;
    logic  sneg_next;
    mag_t  sum_mag_reg;
    logic  sneg_reg;
    mag_t  extra_reg;
    word_t share_reg;
    mag_t  riy_reg;
    mag_t  scaled_reg;

    always_comb
    begin
        if (!ecf_neg)
        begin
            sum_mag_next = p_extra + {16'd0, rate_d_reg[1]};
            sneg_next    = 1'b0;
        end
        else if (p_extra > {16'd0, rate_d_reg[1]})
        begin
            sum_mag_next = p_extra - {16'd0, rate_d_reg[1]};
            sneg_next    = 1'b1;
        end
        else
        begin
            sum_mag_next = {16'd0, rate_d_reg[1]} - p_extra;
            sneg_next    = 1'b0;
        end
    end

    // products by yield and share, stages 25 and 26
    mag_t p_ts;
    mag_t p_te;
    mag_t riy_d_reg    [0:1];
    mag_t scaled_d_reg [0:3];
    logic sneg_d_reg   [0:3];

    dmc_mulq u_mul_ts (.clk(clk), .en(en), .a(sum_mag_reg), .b(inv_yield_reg), .p(p_ts));
    dmc_mulq u_mul_te (.clk(clk), .en(en), .a(extra_reg), .b(share_reg), .p(p_te));

    // products by biomass density and matrix ratio, stages 27 and 28
    mag_t p_sd;
    mag_t p_md;
    mag_t p_ed;
    mag_t p_mg;

    dmc_mulq u_mul_sd (.clk(clk), .en(en), .a(p_ts), .b(side_reg[26].dens), .p(p_sd));
    dmc_mulq u_mul_md (.clk(clk), .en(en), .a(riy_d_reg[1]), .b(side_reg[26].dens),
                       .p(p_md));
    dmc_mulq u_mul_ed (.clk(clk), .en(en), .a(p_te), .b(side_reg[26].dens), .p(p_ed));
    dmc_mulq u_mul_mg (.clk(clk), .en(en), .a(scaled_d_reg[1]), .b(matrix_ratio_reg),
                       .p(p_mg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qm_d_reg[0]   <= qm;
            qm_d_reg[1]   <= qm_d_reg[0];
            rate_d_reg[0] <= rate;
            rate_d_reg[1] <= rate_d_reg[0];
            sum_mag_reg   <= sum_mag_next;
            sneg_reg      <= sneg_next;
            extra_reg     <= p_extra;
            share_reg     <= p_share[WORD_W-1:0];
            riy_reg       <= p_riy;
            scaled_reg    <= p_scaled;
            riy_d_reg[0]  <= riy_reg;
            riy_d_reg[1]  <= riy_d_reg[0];
            scaled_d_reg[0] <= scaled_reg;
            sneg_d_reg[0]   <= sneg_reg;
            for (int k = 1; k < 4; k++)
            begin
                scaled_d_reg[k] <= scaled_d_reg[k-1];
                sneg_d_reg[k]   <= sneg_d_reg[k-1];
            end
        end
    end

    // saturate a magnitude with a sign to signed 32 bits
    function automatic word_t sat_mag(input mag_t mag, input logic neg);
        word_t res;
        if (neg)
        begin
            if (mag >= 48'h0000_8000_0000)
            begin
                res = 32'h8000_0000;
            end
            else
            begin
                res = ~mag[WORD_W-1:0] + 32'd1;
            end
        end
        else
        begin
            if (mag >= 48'h0000_7FFF_FFFF)
            begin
                res = 32'h7FFF_FFFF;
            end
            else
            begin
                res = mag[WORD_W-1:0];
            end
        end
        return res;
    endfunction

    // stage 29: saturation and grid mask
    logic signed [MAG_W+1:0] ng_diff;
    word_t ng_next;
    word_t sd_reg;
    word_t md_reg;
    word_t ed_reg;
    word_t ng_reg;
    word_t mg_reg;
    logic  last_reg;

    assign ng_diff = $signed({2'b00, scaled_d_reg[3]}) - $signed({18'd0, loss_rate_reg});

    always_comb
    begin
        if (ng_diff > 50'sh0_0000_7FFF_FFFF)
        begin
            ng_next = 32'h7FFF_FFFF;
        end
        else if (ng_diff < -50'sh0_0000_8000_0000)
        begin
            ng_next = 32'h8000_0000;
        end
        else
        begin
            ng_next = ng_diff[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // outside the grid only the growth rates are kept
            sd_reg   <= side_reg[28].grid ? sat_mag(p_sd, !sneg_d_reg[3]) : '0;
            md_reg   <= side_reg[28].grid ? sat_mag(p_md, 1'b1) : '0;
            ed_reg   <= side_reg[28].grid ? sat_mag(p_ed, ecf_neg) : '0;
            ng_reg   <= ng_next;
            mg_reg   <= sat_mag(p_mg, 1'b0);
            last_reg <= side_reg[28].last;
        end
    end

    // skid stage: catches the final item when the sink stalls
    word_t sk_sd_reg;
    word_t sk_md_reg;
    word_t sk_ed_reg;
    word_t sk_ng_reg;
    word_t sk_mg_reg;
    logic  sk_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (cell_out.ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (v_reg[LAST_STAGE] && !cell_out.ready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sk_sd_reg   <= sd_reg;
            sk_md_reg   <= md_reg;
            sk_ed_reg   <= ed_reg;
            sk_ng_reg   <= ng_reg;
            sk_mg_reg   <= mg_reg;
            sk_last_reg <= last_reg;
        end
    end

    assign cell_out.valid            = skid_valid_reg || v_reg[LAST_STAGE];
    assign cell_out.substrate_delta  = skid_valid_reg ? sk_sd_reg : sd_reg;
    assign cell_out.metabolite_delta = skid_valid_reg ? sk_md_reg : md_reg;
    assign cell_out.export_delta     = skid_valid_reg ? sk_ed_reg : ed_reg;
    assign cell_out.net_growth       = skid_valid_reg ? sk_ng_reg : ng_reg;
    assign cell_out.matrix_growth    = skid_valid_reg ? sk_mg_reg : mg_reg;
    assign cell_out.last_out         = skid_valid_reg ? sk_last_reg : last_reg;

`ifndef SYNTHESIS
    // a held skid item stays held and keeps its substrate delta and net growth until taken
    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !cell_out.ready |=>
            skid_valid_reg && $stable(sk_sd_reg) && $stable(sk_ng_reg))
        else $error("skid item changed while stalled");

    // a frozen pipe keeps its valid bits
    a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> $stable(v_reg))
        else $error("pipe moved while skid stage full");

    // the sum can only turn negative with a negative export cost factor
    a_sum_sign: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[24] && sneg_reg |-> ecf_neg)
        else $error("negative sum with positive export cost factor");

    // metabolite consumption never yields a positive delta
    a_md_sign: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[LAST_STAGE] |-> (md_reg[WORD_W-1] || md_reg == '0))
        else $error("positive metabolite delta");
`endif

endmodule

/* hdl/dmc_div.sv */
// pipelined restoring divider: floor(conc * 2^16 / (conc + aff)), one bit per stage
module dmc_div (
    input  logic          clk,
    input  logic          en,
    input  dmc_pkg::word_t conc,
    input  dmc_pkg::word_t aff,
    output dmc_pkg::quo_t  quo
);
    import dmc_pkg::*;

    rem_t rem_reg [DIV_STAGES];
    rem_t den_reg [DIV_STAGES];
    quo_t quo_reg [DIV_STAGES];
    rem_t rem_next [DIV_STAGES];
    rem_t den_next [DIV_STAGES];
    quo_t quo_next [DIV_STAGES];

    always_comb
    begin
        rem_t                 den0;
        rem_t                 r_in;
        rem_t                 d_in;
        quo_t                 q_in;
        logic                 nbit;
        logic [REM_W:0]       trial;
        den0 = {1'b0, conc} + {1'b0, aff};
        // both zero: divide 0 by 1 so the quotient is zero
        if (den0 == '0)
        begin
            den0 = rem_t'(1);
        end
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                r_in = {2'b0, conc[WORD_W-1:1]};
                d_in = den0;
                q_in = '0;
                nbit = conc[0];
            end
            else
            begin
                r_in = rem_reg[k-1];
                d_in = den_reg[k-1];
                q_in = quo_reg[k-1];
                nbit = 1'b0;
            end
            trial = {r_in, nbit};
            if (trial >= {1'b0, d_in})
            begin
                rem_next[k] = REM_W'(trial - {1'b0, d_in});
                quo_next[k] = {q_in[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[REM_W-1:0];
                quo_next[k] = {q_in[QUO_W-2:0], 1'b0};
            end
            den_next[k] = d_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_next[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

/* hdl/dmc_mulq.sv */
// two-stage q16.16 magnitude multiplier, floor(a * b / 2^16), saturating
module dmc_mulq (
    input  logic           clk,
    input  logic           en,
    input  dmc_pkg::mag_t  a,
    input  dmc_pkg::word_t b,
    output dmc_pkg::mag_t  p
);
    import dmc_pkg::*;

    logic [2*WORD_W-1:0]           lo_reg;
    logic [MAG_W-1:0]              hi_reg;
    logic [2*WORD_W-1:0]           lo_next;
    logic [MAG_W-1:0]              hi_next;
    logic [MAG_W+WORD_W-1:0]       full;
    logic [MAG_W+WORD_W-17:0]      shifted;
    mag_t                          p_next;
    mag_t                          p_reg;

    // partial products on the low and high part of a
    assign lo_next = {{WORD_W{1'b0}}, a[WORD_W-1:0]} * {{WORD_W{1'b0}}, b};
    assign hi_next = {{WORD_W{1'b0}}, a[MAG_W-1:WORD_W]} * {{(MAG_W-WORD_W){1'b0}}, b};

    assign full    = {hi_reg, {WORD_W{1'b0}}} + {{(MAG_W-WORD_W){1'b0}}, lo_reg};
    assign shifted = full[MAG_W+WORD_W-1:16];

    always_comb
    begin
        if (shifted[MAG_W+WORD_W-17:MAG_W-1] != '0)
        begin
            p_next = MAG_SAT;
        end
        else
        begin
            p_next = shifted[MAG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule
